FILE: rtl/sgm_pkg.sv
package sgm_pkg;

    // Largest supported row length; sets the depth of the line store.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 16;
    localparam int FW_W      = 12;
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 12;
    localparam int SUM_W     = 22;

    localparam logic [FW_W-1:0] WIDTH_MIN  = FW_W'(2);
    localparam logic [FW_W-1:0] WIDTH_MAX  = FW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_MIN = ROW_W'(2);
    localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(512);
    localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(512);

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PICK,
        ST_SUM,
        ST_ROOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic update;
        logic grad;
        logic square;
        logic root_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mask_empty;
        logic root_done;
        logic out_free;
    } status_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t window_t [3][3];

endpackage

FILE: rtl/sgm_ram.sv
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sgm_ctrl.sv
module sgm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sgm_pkg::status_t status,
    output sgm_pkg::cmd_t    cmd
);

    sgm_pkg::state_t state_reg;
    sgm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sgm_pkg::ST_READ;
                end
            end
            sgm_pkg::ST_READ: state_next = sgm_pkg::ST_PICK;
            sgm_pkg::ST_PICK:
            begin
                state_next = status.mask_empty ? sgm_pkg::ST_IDLE : sgm_pkg::ST_SUM;
            end
            sgm_pkg::ST_SUM: state_next = sgm_pkg::ST_ROOT;
            sgm_pkg::ST_ROOT:
            begin
                if (status.root_done)
                begin
                    state_next = sgm_pkg::ST_EMIT;
                end
            end
            sgm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = sgm_pkg::ST_PICK;
                end
            end
            default: state_next = sgm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sgm_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            sgm_pkg::ST_READ: cmd.update = 1'b1;
            sgm_pkg::ST_PICK: cmd.grad = !status.mask_empty;
            sgm_pkg::ST_SUM:  cmd.square = 1'b1;
            sgm_pkg::ST_ROOT: cmd.root_step = 1'b1;
            sgm_pkg::ST_EMIT: cmd.emit = status.out_free;
            default:          in_stall = 1'b1;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A request is taken only from the idle state and always leads to the line store read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == sgm_pkg::ST_READ))
        else $error("accepted request did not start the read");

    // Only one datapath command is active in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.update, cmd.grad, cmd.square, cmd.root_step, cmd.emit}))
        else $error("more than one datapath command");

    // The square root always follows the squaring step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.square) |-> (state_reg == sgm_pkg::ST_ROOT))
        else $error("square root did not follow squaring");
`endif

endmodule

FILE: rtl/sgm_datapath.sv
module sgm_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sgm_pkg::cmd_t               cmd,
    output sgm_pkg::status_t            status,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic [sgm_pkg::PIX_W-1:0]   pixel,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  magnitude,
    output logic [sgm_pkg::ROW_W-1:0]   out_row,
    output logic [sgm_pkg::COL_W-1:0]   out_col,
    output logic                        last,
    output logic                        frame_done
);

    logic [sgm_pkg::FW_W-1:0]  width_reg;
    logic [sgm_pkg::ROW_W-1:0] height_reg;
    logic [sgm_pkg::COL_W-1:0] col_count_reg;
    logic [sgm_pkg::ROW_W-1:0] row_count_reg;
    logic [sgm_pkg::COL_W-1:0] cur_col_reg;
    logic [sgm_pkg::ROW_W-1:0] cur_row_reg;
    logic [sgm_pkg::PIX_W-1:0] pixel_reg;
    sgm_pkg::window_t          win_reg;
    logic [3:0]                mask_reg;
    logic [1:0]                cand_reg;
    logic signed [sgm_pkg::GRAD_W-1:0] gx_reg;
    logic signed [sgm_pkg::GRAD_W-1:0] gy_reg;
    logic [15:0]               n_reg;
    logic                      sat_reg;
    logic [7:0]                root_reg;
    logic [7:0]                bit_reg;
    logic                      out_valid_reg;
    logic [7:0]                mag_out_reg;
    logic [sgm_pkg::ROW_W-1:0] row_out_reg;
    logic [sgm_pkg::COL_W-1:0] col_out_reg;
    logic                      last_out_reg;
    logic                      done_out_reg;

    logic [sgm_pkg::FW_W-1:0]  w_eff;
    logic [sgm_pkg::ROW_W-1:0] h_eff;
    logic                      outside;
    logic [sgm_pkg::COL_W-1:0] j_start;
    logic [sgm_pkg::ROW_W-1:0] i_start;
    logic [15:0]               ram_rdata;
    logic [15:0]               ram_wdata;
    logic [sgm_pkg::PIX_W-1:0] up_pix;
    logic [sgm_pkg::PIX_W-1:0] lo_pix;
    logic                      i_ge1;
    logic                      j_ge1;
    logic                      j_end;
    logic                      i_end;
    logic [1:0]                next_cand;
    logic [1:0]                rs [3];
    logic [1:0]                cs [3];
    logic signed [sgm_pkg::GRAD_W-1:0] p [3][3];
    logic signed [sgm_pkg::GRAD_W-1:0] gx;
    logic signed [sgm_pkg::GRAD_W-1:0] gy;
    logic signed [2*sgm_pkg::GRAD_W-1:0] gx_sq;
    logic signed [2*sgm_pkg::GRAD_W-1:0] gy_sq;
    logic [sgm_pkg::SUM_W-1:0] sum;
    logic [7:0]                trial;
    logic [15:0]               trial_sq;
    logic [3:0]                cand_hot;
    logic [3:0]                mask_left;
    logic                      out_free;

    // Out-of-range register values are clamped into the supported frame.
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < sgm_pkg::WIDTH_MIN)
        begin
            w_eff = sgm_pkg::WIDTH_MIN;
        end
        else if (width_reg > sgm_pkg::WIDTH_MAX)
        begin
            w_eff = sgm_pkg::WIDTH_MAX;
        end
        h_eff = (height_reg < sgm_pkg::HEIGHT_MIN) ? sgm_pkg::HEIGHT_MIN : height_reg;
    end

    assign outside = ({1'b0, col_count_reg} >= w_eff) || (row_count_reg >= h_eff);
    assign j_start = outside ? '0 : col_count_reg;
    assign i_start = outside ? '0 : row_count_reg;

    // Both line stores share one word: upper row in the high byte.
    assign up_pix    = ram_rdata[15:8];
    assign lo_pix    = ram_rdata[7:0];
    assign ram_wdata = {lo_pix, pixel_reg};

    sgm_ram #(
        .WIDTH (16),
        .DEPTH (sgm_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (cur_col_reg),
        .wdata (ram_wdata),
        .re    (cmd.start),
        .raddr (j_start),
        .rdata (ram_rdata)
    );

    assign i_ge1 = (cur_row_reg != '0);
    assign j_ge1 = (cur_col_reg != '0);
    assign j_end = ({1'b0, cur_col_reg} == (w_eff - sgm_pkg::FW_W'(1)));
    assign i_end = (cur_row_reg == (h_eff - sgm_pkg::ROW_W'(1)));

    always_comb
    begin
        next_cand = 2'd3;
        if (mask_reg[0])
        begin
            next_cand = 2'd0;
        end
        else if (mask_reg[1])
        begin
            next_cand = 2'd1;
        end
        else if (mask_reg[2])
        begin
            next_cand = 2'd2;
        end
    end

    // Window rows and columns for the chosen output, with mirrored borders.
    always_comb
    begin
        rs[0] = next_cand[1] ? 2'd1 : ((cur_row_reg == sgm_pkg::ROW_W'(1)) ? 2'd2 : 2'd0);
        rs[1] = next_cand[1] ? 2'd2 : 2'd1;
        rs[2] = next_cand[1] ? 2'd1 : 2'd2;
        cs[0] = next_cand[0] ? 2'd1 : ((cur_col_reg == sgm_pkg::COL_W'(1)) ? 2'd2 : 2'd0);
        cs[1] = next_cand[0] ? 2'd2 : 2'd1;
        cs[2] = next_cand[0] ? 2'd1 : 2'd2;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                p[a][b] = $signed({4'b0, win_reg[rs[a]][cs[b]]});
            end
        end
        gx = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
        gy = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
    end

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;
    assign sum   = gx_sq[sgm_pkg::SUM_W-1:0] + gy_sq[sgm_pkg::SUM_W-1:0];

    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    assign cand_hot  = 4'b0001 << cand_reg;
    assign mask_left = mask_reg & ~cand_hot;
    assign out_free  = !out_valid_reg || !out_stall;

    assign status.mask_empty = (mask_reg == '0);
    assign status.root_done  = sat_reg || (bit_reg == '0);
    assign status.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= sgm_pkg::WIDTH_RST;
            height_reg    <= sgm_pkg::HEIGHT_RST;
            col_count_reg <= '0;
            row_count_reg <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    win_reg[a][b] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sgm_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[sgm_pkg::FW_W-1:0];
                    sgm_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:                   width_reg  <= width_reg;
                endcase
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
            if (cmd.update)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    win_reg[a][0] <= win_reg[a][1];
                    win_reg[a][1] <= win_reg[a][2];
                end
                win_reg[0][2] <= up_pix;
                win_reg[1][2] <= lo_pix;
                win_reg[2][2] <= pixel_reg;
                mask_reg <= {i_end && j_end, i_end && j_ge1,
                             i_ge1 && j_end, i_ge1 && j_ge1};
                if (j_end)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= i_end ? '0 : cur_row_reg + sgm_pkg::ROW_W'(1);
                end
                else
                begin
                    col_count_reg <= cur_col_reg + sgm_pkg::COL_W'(1);
                    row_count_reg <= cur_row_reg;
                end
            end
            if (cmd.emit)
            begin
                mask_reg <= mask_left;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pixel_reg   <= pixel;
            cur_col_reg <= j_start;
            cur_row_reg <= i_start;
        end
        if (cmd.grad)
        begin
            cand_reg <= next_cand;
            gx_reg   <= gx;
            gy_reg   <= gy;
        end
        if (cmd.square)
        begin
            n_reg    <= sum[15:0];
            sat_reg  <= (sum[sgm_pkg::SUM_W-1:16] != '0);
            root_reg <= '0;
            bit_reg  <= 8'h80;
        end
        else if (cmd.root_step && (bit_reg != '0))
        begin
            if (trial_sq <= n_reg)
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.emit)
        begin
            mag_out_reg  <= sat_reg ? 8'hFF : root_reg;
            row_out_reg  <= cand_reg[1] ? (h_eff - sgm_pkg::ROW_W'(1))
                                        : (cur_row_reg - sgm_pkg::ROW_W'(1));
            col_out_reg  <= cand_reg[0] ? sgm_pkg::COL_W'(w_eff - sgm_pkg::FW_W'(1))
                                        : (cur_col_reg - sgm_pkg::COL_W'(1));
            last_out_reg <= (mask_left == '0);
            done_out_reg <= (cand_reg == 2'd3);
        end
    end

    assign out_valid  = out_valid_reg;
    assign magnitude  = mag_out_reg;
    assign out_row    = row_out_reg;
    assign out_col    = col_out_reg;
    assign last       = last_out_reg;
    assign frame_done = done_out_reg;

`ifndef NO_ASSERTIONS
    // The column position counter stays inside the clamped frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_count_reg} < w_eff) || $past(cfg_write))
        else $error("column counter left the frame");

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

    // Only a pending output position is emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> mask_reg[cand_reg])
        else $error("emitted a position that was not pending");

    // The root search starts from the top bit after every squaring.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.square) |-> (bit_reg == 8'h80))
        else $error("root search did not restart");
`endif

endmodule

FILE: rtl/sobel_gradient_magnitude.sv
// Sobel edge magnitude over a raster stream of 8-bit grayscale pixels. Each pixel request is
// handled on its own: taking it reads both stored lines at the pixel's column, the next state
// shifts the 3x3 window and writes the lines back, and then each result the pixel completes
// passes through gradient, squaring, the eight-step bit-serial square root (cut short when the
// squared sum saturates) and the output load, which waits while the output register stays
// stalled. A pixel completes no result, one result, or up to four at the bottom right corner.
// These results share one square root unit and are made one after another, and no new pixel
// is taken before the last is loaded. Results come out one row and one column behind
// the input, tagged with their row and column; last marks the final result a pixel caused and
// frame_done the bottom right pixel. Borders are mirrored without repeating the edge pixel. A
// new pixel is taken while the final result still waits in the output register. Writing
// frame_width or frame_height restarts at the top left of a new frame; the line memory needs
// no clearing.
module sobel_gradient_magnitude (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [sgm_pkg::PIX_W-1:0] pixel,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                magnitude,
    output logic [sgm_pkg::ROW_W-1:0] out_row,
    output logic [sgm_pkg::COL_W-1:0] out_col,
    output logic                      last,
    output logic                      frame_done
);

    // Commands from the sequencer and status back from the datapath.
    sgm_pkg::cmd_t    cmd;
    sgm_pkg::status_t status;

    sgm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sgm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .magnitude  (magnitude),
        .out_row    (out_row),
        .out_col    (out_col),
        .last       (last),
        .frame_done (frame_done)
    );

endmodule
